// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("assertion failed: forbidden condition seen");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication broken");

`endif

// ===== rtl/sct_pkg.sv =====
// Types and constants shared by the shell command tokenizer.
`timescale 1ns / 1ps

package sct_pkg;

	localparam int TOKEN_BUFFER_LEN = 256;
	localparam int WLEN_W           = $clog2(TOKEN_BUFFER_LEN);
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	typedef enum logic [3:0] {
		K_CHAR   = 4'd0,
		K_WEND   = 4'd1,
		K_PIPE   = 4'd2,
		K_IN     = 4'd3,
		K_OUT    = 4'd4,
		K_APPEND = 4'd5,
		K_BG     = 4'd6,
		K_END    = 4'd7,
		K_ERR_SQ = 4'd8,
		K_ERR_DQ = 4'd9
	} kind_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       line_end;
	} in_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_value;
		logic       last_of_item;
	} out_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
	} tok_t;

	// Tokens caused by one input byte: cnt is 0, 1 or 2.
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       tok_a;
		tok_t       tok_b;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== rtl/sct_front.sv =====
// Lexer front end: takes bytes, tracks quoting mode, builds token commands.
`timescale 1ns / 1ps

module sct_front import sct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_t       in_data,
	input  q_status_t q_stat,
	output logic      push,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_WORD  = 3'd1,
		M_ESC   = 3'd2,
		M_SQ    = 3'd3,
		M_DQ    = 3'd4,
		M_DQESC = 3'd5,
		M_GT    = 3'd6
	} mode_t;

	localparam logic [WLEN_W-1:0] LEN_MAX = WLEN_W'(TOKEN_BUFFER_LEN - 1);

	mode_t             mode_q, mode_d;
	logic [WLEN_W-1:0] len_q, len_d;

	function automatic cmd_t add_tok(cmd_t c, kind_t k, logic [7:0] ch);
		cmd_t r;
		r = c;
		if (c.cnt == 2'd0) begin
			r.tok_a = '{kind: k, ch: ch};
			r.cnt   = 2'd1;
		end else if (c.cnt == 2'd1) begin
			r.tok_b = '{kind: k, ch: ch};
			r.cnt   = 2'd2;
		end
		return r;
	endfunction

	logic [7:0] c;
	logic       blank, is_op;
	logic       do_idle, do_op, do_wb, push_c;

	assign c        = in_data.char_in;
	assign blank    = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	assign is_op    = (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT) || (c == CH_AMP);
	assign in_ready = !q_stat.full;

	always_comb begin
		cmd     = '0;
		mode_d  = mode_q;
		len_d   = len_q;
		do_idle = 1'b0;
		do_op   = 1'b0;
		do_wb   = 1'b0;
		push_c  = 1'b0;
		if (in_data.line_end) begin
			unique case (mode_q)
				M_SQ: cmd = add_tok(cmd, K_ERR_SQ, 8'h00);
				M_DQ, M_DQESC: cmd = add_tok(cmd, K_ERR_DQ, 8'h00);
				M_WORD, M_ESC: begin
					if (len_q != '0) cmd = add_tok(cmd, K_WEND, 8'h00);
					cmd = add_tok(cmd, K_END, 8'h00);
				end
				M_GT: begin
					cmd = add_tok(cmd, K_OUT, 8'h00);
					cmd = add_tok(cmd, K_END, 8'h00);
				end
				default: cmd = add_tok(cmd, K_END, 8'h00);
			endcase
			mode_d = M_IDLE;
			len_d  = '0;
		end else begin
			unique case (mode_q)
				M_WORD: begin
					if (blank || is_op) begin
						if (len_q != '0) cmd = add_tok(cmd, K_WEND, 8'h00);
						len_d  = '0;
						mode_d = M_IDLE;
						do_op  = is_op;
					end else begin
						do_wb = 1'b1;
					end
				end
				M_ESC: begin
					push_c = 1'b1;
					mode_d = M_WORD;
				end
				M_SQ: begin
					if (c == CH_SQUOTE) mode_d = M_WORD;
					else push_c = 1'b1;
				end
				M_DQ: begin
					if (c == CH_DQUOTE) mode_d = M_WORD;
					else if (c == CH_BSLASH) mode_d = M_DQESC;
					else push_c = 1'b1;
				end
				M_DQESC: begin
					push_c = 1'b1;
					mode_d = M_DQ;
				end
				M_GT: begin
					mode_d = M_IDLE;
					if (c == CH_GT) begin
						cmd = add_tok(cmd, K_APPEND, 8'h00);
					end else begin
						cmd     = add_tok(cmd, K_OUT, 8'h00);
						do_idle = 1'b1;
					end
				end
				default: do_idle = 1'b1;
			endcase

			// byte seen between tokens
			if (do_idle) begin
				mode_d = M_IDLE;
				if (is_op) begin
					do_op = 1'b1;
				end else if (!blank) begin
					len_d = '0;
					do_wb = 1'b1;
				end
			end

			if (do_op) begin
				mode_d = M_IDLE;
				priority if (c == CH_PIPE) cmd = add_tok(cmd, K_PIPE, 8'h00);
				else if (c == CH_LT) cmd = add_tok(cmd, K_IN, 8'h00);
				else if (c == CH_AMP) cmd = add_tok(cmd, K_BG, 8'h00);
				else mode_d = M_GT;
			end

			// plain word byte outside quotes
			if (do_wb) begin
				priority if (c == CH_BSLASH) mode_d = M_ESC;
				else if (c == CH_SQUOTE) mode_d = M_SQ;
				else if (c == CH_DQUOTE) mode_d = M_DQ;
				else begin
					mode_d = M_WORD;
					push_c = 1'b1;
				end
			end

			// drop characters past the buffer limit
			if (push_c && (len_d < LEN_MAX)) begin
				cmd   = add_tok(cmd, K_CHAR, c);
				len_d = len_d + 1'b1;
			end
		end
	end

	assign push = in_valid && in_ready && (cmd.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			len_q  <= '0;
		end else if (in_valid && in_ready) begin
			mode_q <= mode_d;
			len_q  <= len_d;
		end
	end

endmodule

// ===== rtl/sct_queue.sv =====
// Short command queue between the lexer front end and the token sender.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sct_queue import sct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_data,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t stat
);

	cmd_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && stat.full)
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && stat.empty)
	`ASSERT_IMPLIES(a_head_nonempty, clk, arst_n, !stat.empty, head.cnt != 2'd0)

endmodule

// ===== rtl/sct_back.sv =====
// Token sender: unpacks queued commands into single results.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sct_back import sct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  q_status_t q_stat,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_t      out_data
);

	logic out_valid_q;
	out_t out_q;
	logic phase_q;
	logic load;
	tok_t tok;

	assign load = (!out_valid_q || out_ready) && !q_stat.empty;
	assign tok  = phase_q ? head.tok_b : head.tok_a;
	assign pop  = load && (phase_q || head.cnt == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= !q_stat.empty;
			if (load) phase_q <= !pop;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.kind         <= tok.kind;
			out_q.char_value   <= tok.ch;
			out_q.last_of_item <= pop;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_IMPLIES(a_phase_has_second, clk, arst_n, phase_q, (!q_stat.empty) && (head.cnt == 2'd2))
	`ASSERT_IMPLIES(a_char_zero, clk, arst_n, out_valid_q && (out_q.kind != K_CHAR),
		out_q.char_value == 8'h00)
	`ASSERT_IMPLIES(a_second_is_last, clk, arst_n, load && phase_q, pop)

endmodule

// ===== rtl/shell_command_tokenizer_core.sv =====
// Top level of the streaming shell command-line tokenizer.
`timescale 1ns / 1ps

// Usage
//   in_valid / in_ready / in_data: one request per byte of the command line
//   (in_data.char_in), closed by a request with in_data.line_end set.
//   out_valid / out_ready / out_data: one request per token: word characters,
//   word end, pipe, redirections, background, end of line or a quote error.
//   out_data.last_of_item marks the final token caused by one input request.
// Timing
//   Input requests are taken one per cycle while the four-entry command queue
//   has room. A request's first token passes through a queue entry and then
//   the output register. While out_ready is high the output stage sends one
//   token per cycle; the queue absorbs short bursts.
// Stalls
//   A stalled receiver holds the output register; the front keeps taking bytes
//   until the queue fills, then drops in_ready.
// Reset
//   arst_n clears the lexer to its idle mode with an empty word, empties the
//   queue and drops out_valid. Any end of line returns the lexer to that state.

module shell_command_tokenizer_core import sct_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	q_status_t q_stat;
	logic      push, pop;
	cmd_t      cmd, head;

	// Classify each byte and turn it into zero, one or two tokens.
	sct_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.push     (push),
		.cmd      (cmd)
	);

	// Hold commands so the front and the sender stall independently.
	sct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	// Send the queued tokens one at a time through the output register.
	sct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
